[hw/rtl/pfq_pkg.sv]
// Shared types, codes and default sizes for the per-flow round-robin event queue.
// No dependencies; imported by every module of the block except pfq_ram.
package pfq_pkg;

  localparam int NUM_FLOWS_DEF  = 64;
  localparam int FLOW_DEPTH_DEF = 8;

  localparam int FUNC_W      = 2;
  localparam int SERVER_W    = 16;
  localparam int SESSION_W   = 32;
  localparam int KEY_W       = SERVER_W + SESSION_W;
  localparam int KIND_W      = 2;
  localparam int HANDLE_W    = 32;
  localparam int EV_W        = KIND_W + HANDLE_W;
  localparam int STATUS_W    = 3;
  localparam int TDATA_W     = 88;
  localparam int OUT_TUSER_W = STATUS_W + 1;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_REM = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_TBL_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FIFO_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_REM_BUSY  = 3'd4;

  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

endpackage

[hw/rtl/pfq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  raddr,
  output logic [W-1:0]                        rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/pfq_front.sv]
// Front end: takes input transfers, classifies func into an operation and
// holds up to two decoded commands for the back end. Uses pfq_pkg.
module pfq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [pfq_pkg::TDATA_W-1:0]  in_tdata,
  input  logic [pfq_pkg::FUNC_W-1:0]   in_tuser,
  output logic                         cmd_valid,
  output pfq_pkg::cmd_t                cmd,
  input  logic                         cmd_pop
);
  import pfq_pkg::*;

  cmd_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  cmd_t       dec;
  logic       push, pop;

  // func maps one to one onto the operation codes; the unused code is OP_NOP
  always_comb begin
    dec.op     = op_t'(in_tuser);
    dec.key    = in_tdata[KEY_W-1:0];
    dec.kind   = in_tdata[KEY_W +: KIND_W];
    dec.handle = in_tdata[KEY_W+KIND_W +: HANDLE_W];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end
endmodule

[hw/rtl/pfq_back.sv]
// Back end: sequencer that runs one command against the flow table, per-flow
// FIFOs and ready ring, and holds the result register. Uses pfq_pkg, pfq_ram.
module pfq_back #(
  parameter int NUM_FLOWS  = pfq_pkg::NUM_FLOWS_DEF,
  parameter int FLOW_DEPTH = pfq_pkg::FLOW_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  input  pfq_pkg::cmd_t                    cmd,
  output logic                             cmd_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pfq_pkg::TDATA_W-1:0]      out_tdata,
  output logic [pfq_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import pfq_pkg::*;

  localparam int FW     = $clog2(NUM_FLOWS);
  localparam int HW     = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
  localparam int CW     = $clog2(FLOW_DEPTH + 1);
  localparam int MW     = HW + CW;
  localparam int RCW    = $clog2(NUM_FLOWS + 1);
  localparam int EV_D   = NUM_FLOWS * FLOW_DEPTH;
  localparam int EAW    = $clog2(EV_D);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCAN    = 9'b000000010,
    S_DECIDE  = 9'b000000100,
    S_ENQ     = 9'b000001000,
    S_REM     = 9'b000010000,
    S_DQ_RING = 9'b000100000,
    S_DQ_META = 9'b001000000,
    S_DQ_EV   = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;

  logic [FW-1:0]  scan_idx_r, scan_idx_nxt, cmp_idx_r, cmp_idx_nxt;
  logic           issue_done_r, issue_done_nxt, cmp_vld_r, cmp_vld_nxt;
  logic           hit_r, hit_nxt, free_ok_r, free_ok_nxt, new_r, new_nxt;
  logic [FW-1:0]  hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [FW-1:0]  flow_r, flow_nxt;
  logic           in_use_r [NUM_FLOWS];
  logic           in_use_nxt [NUM_FLOWS];
  logic [FW-1:0]  ring_head_r, ring_head_nxt;
  logic [RCW-1:0] ring_cnt_r, ring_cnt_nxt;
  logic [KEY_W-1:0] key_q_r, key_q_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_ev_r, res_ev_nxt;
  logic [KEY_W-1:0]    res_key_r, res_key_nxt;
  logic [EV_W-1:0]     res_event_r, res_event_nxt;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [TDATA_W-1:0]     out_tdata_r, out_tdata_nxt;
  logic [OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  // memory ports
  logic             key_we;
  logic [FW-1:0]    key_waddr, key_raddr;
  logic [KEY_W-1:0] key_rdata;
  logic             meta_we;
  logic [FW-1:0]    meta_waddr, meta_raddr;
  logic [MW-1:0]    meta_wdata, meta_rdata;
  logic             ev_we;
  logic [EAW-1:0]   ev_waddr, ev_raddr;
  logic [EV_W-1:0]  ev_wdata, ev_rdata;
  logic             ring_we;
  logic [FW-1:0]    ring_waddr, ring_raddr, ring_wdata, ring_rdata;

  // scratch
  logic [HW-1:0]   cur_head;
  logic [CW-1:0]   cur_cnt;
  logic [CW:0]     slot_sum;
  logic [HW-1:0]   slot;
  logic [FW:0]     tail_sum;
  logic [FW-1:0]   ring_tail;
  logic [EAW-1:0]  flow_base;
  logic            out_free;

  pfq_ram #(.W(KEY_W), .D(NUM_FLOWS)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(cmd_r.key),
    .raddr(key_raddr), .rdata(key_rdata)
  );
  pfq_ram #(.W(MW), .D(NUM_FLOWS)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );
  pfq_ram #(.W(EV_W), .D(EV_D)) u_ev_ram (
    .clk(clk), .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata),
    .raddr(ev_raddr), .rdata(ev_rdata)
  );
  pfq_ram #(.W(FW), .D(NUM_FLOWS)) u_ring_ram (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // meta word is {count, head}
  assign cur_head  = new_r ? '0 : meta_rdata[HW-1:0];
  assign cur_cnt   = new_r ? '0 : meta_rdata[MW-1:HW];
  assign slot_sum  = (CW+1)'(cur_head) + (CW+1)'(cur_cnt);
  assign slot      = (slot_sum >= (CW+1)'(FLOW_DEPTH)) ?
                     HW'(slot_sum - (CW+1)'(FLOW_DEPTH)) : HW'(slot_sum);
  assign flow_base = EAW'(flow_r) * EAW'(FLOW_DEPTH);
  assign tail_sum  = (FW+1)'(ring_head_r) + (FW+1)'(ring_cnt_r);
  assign ring_tail = (tail_sum >= (FW+1)'(NUM_FLOWS)) ?
                     FW'(tail_sum - (FW+1)'(NUM_FLOWS)) : FW'(tail_sum);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = cmp_vld_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_ok_nxt    = free_ok_r;
    free_idx_nxt   = free_idx_r;
    new_nxt        = new_r;
    flow_nxt       = flow_r;
    in_use_nxt     = in_use_r;
    ring_head_nxt  = ring_head_r;
    ring_cnt_nxt   = ring_cnt_r;
    key_q_nxt      = key_q_r;
    res_status_nxt = res_status_r;
    res_ev_nxt     = res_ev_r;
    res_key_nxt    = res_key_r;
    res_event_nxt  = res_event_r;
    cmd_pop        = 1'b0;
    key_we = 1'b0; key_waddr = flow_r; key_raddr = scan_idx_r;
    meta_we = 1'b0; meta_waddr = flow_r; meta_wdata = '0; meta_raddr = hit_idx_r;
    ev_we = 1'b0; ev_waddr = flow_base + EAW'(slot);
    ev_wdata = {cmd_r.kind, cmd_r.handle};
    ev_raddr = flow_base + EAW'(cur_head);
    ring_we = 1'b0; ring_waddr = ring_tail; ring_wdata = flow_r; ring_raddr = ring_head_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          cmd_nxt        = cmd;
          res_status_nxt = STAT_OK;
          res_ev_nxt     = 1'b0;
          res_key_nxt    = '0;
          res_event_nxt  = '0;
          scan_idx_nxt   = '0;
          issue_done_nxt = 1'b0;
          cmp_vld_nxt    = 1'b0;
          hit_nxt        = 1'b0;
          free_ok_nxt    = 1'b0;
          case (cmd.op)
            OP_ENQ, OP_REM: state_nxt = S_SCAN;
            OP_DEQ: begin
              if (ring_cnt_r == '0) begin
                res_status_nxt = STAT_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_DQ_RING;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        // one key read issued per cycle, compared in the following cycle
        cmp_vld_nxt = !issue_done_r;
        cmp_idx_nxt = scan_idx_r;
        if (!issue_done_r) begin
          if (scan_idx_r == FW'(NUM_FLOWS - 1)) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + FW'(1);
          end
        end
        if (cmp_vld_r) begin
          if (in_use_r[cmp_idx_r] && key_rdata == cmd_r.key && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
          end
          if (!in_use_r[cmp_idx_r] && !free_ok_r) begin
            free_ok_nxt  = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (issue_done_r) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        meta_raddr = hit_idx_r;
        if (hit_r) begin
          flow_nxt  = hit_idx_r;
          new_nxt   = 1'b0;
          state_nxt = (cmd_r.op == OP_ENQ) ? S_ENQ : S_REM;
        end else if (cmd_r.op == OP_ENQ && free_ok_r) begin
          // claim the lowest free slot
          flow_nxt               = free_idx_r;
          new_nxt                = 1'b1;
          in_use_nxt[free_idx_r] = 1'b1;
          key_we                 = 1'b1;
          key_waddr              = free_idx_r;
          state_nxt              = S_ENQ;
        end else begin
          res_status_nxt = (cmd_r.op == OP_ENQ) ? STAT_TBL_FULL : STAT_OK;
          state_nxt      = S_RESP;
        end
      end
      S_ENQ: begin
        if (cur_cnt == CW'(FLOW_DEPTH)) begin
          res_status_nxt = STAT_FIFO_FULL;
        end else begin
          ev_we      = 1'b1;
          meta_we    = 1'b1;
          meta_wdata = {cur_cnt + CW'(1), cur_head};
          if (cur_cnt == '0 && ring_cnt_r != RCW'(NUM_FLOWS)) begin
            ring_we      = 1'b1;
            ring_cnt_nxt = ring_cnt_r + RCW'(1);
          end
        end
        state_nxt = S_RESP;
      end
      S_REM: begin
        if (cur_cnt != '0) begin
          res_status_nxt = STAT_REM_BUSY;
        end else begin
          in_use_nxt[flow_r] = 1'b0;
        end
        state_nxt = S_RESP;
      end
      S_DQ_RING: begin
        flow_nxt   = ring_rdata;
        new_nxt    = 1'b0;
        key_raddr  = ring_rdata;
        meta_raddr = ring_rdata;
        ring_head_nxt = (ring_head_r == FW'(NUM_FLOWS - 1)) ? '0 : ring_head_r + FW'(1);
        ring_cnt_nxt  = ring_cnt_r - RCW'(1);
        state_nxt     = S_DQ_META;
      end
      S_DQ_META: begin
        key_q_nxt = key_rdata;
        if (cur_cnt == '0) begin
          res_status_nxt = STAT_EMPTY;
          state_nxt      = S_RESP;
        end else begin
          meta_we    = 1'b1;
          meta_wdata = {cur_cnt - CW'(1),
                        (cur_head == HW'(FLOW_DEPTH - 1)) ? HW'(0) : cur_head + HW'(1)};
          if (cur_cnt != CW'(1) && ring_cnt_r != RCW'(NUM_FLOWS)) begin
            ring_we      = 1'b1;
            ring_cnt_nxt = ring_cnt_r + RCW'(1);
          end
          state_nxt = S_DQ_EV;
        end
      end
      S_DQ_EV: begin
        res_status_nxt = STAT_OK;
        res_ev_nxt     = 1'b1;
        res_key_nxt    = key_q_r;
        res_event_nxt  = ev_rdata;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (state_r == S_RESP && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = TDATA_W'({res_event_r[HANDLE_W-1:0], res_event_r[EV_W-1:HANDLE_W],
                                 res_key_r});
      out_tuser_nxt  = {res_ev_r, res_status_r};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      ring_head_r  <= '0;
      ring_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NUM_FLOWS; i++) begin
        in_use_r[i] <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      ring_head_r  <= ring_head_nxt;
      ring_cnt_r   <= ring_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      in_use_r     <= in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_ok_r    <= free_ok_nxt;
    free_idx_r   <= free_idx_nxt;
    new_r        <= new_nxt;
    flow_r       <= flow_nxt;
    key_q_r      <= key_q_nxt;
    res_status_r <= res_status_nxt;
    res_ev_r     <= res_ev_nxt;
    res_key_r    <= res_key_nxt;
    res_event_r  <= res_event_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end
endmodule

[hw/rtl/per_flow_round_robin_event_queue.sv]
// Top level of the per-flow round-robin event queue.
// Depends on pfq_pkg, pfq_front, pfq_back (and pfq_ram through pfq_back).
//
// Events tagged with a 48-bit flow key {server id, session id} are held in one
// FIFO per flow; dequeue serves the ready flows in round-robin order. Each
// input transfer gives exactly one output transfer, in order. A two-entry
// command queue sits between the front end and the sequencer, and the result
// sits in an output register, so the input keeps accepting while a result
// waits. The flow table is searched by reading its key memory one entry per
// cycle for enqueue and remove; dequeue reads the ring, flow state and event,
// then sets the result, and the unused func code goes straight to the result.
// No clearing pass is needed after reset: only the in-use bits and the ring
// head and count are reset, and each flow's FIFO state is written when it is
// claimed. Status codes: 0 ok, 1 nothing queued, 2 flow table full, 3 flow
// FIFO full, 4 remove refused because the flow still holds events.
module per_flow_round_robin_event_queue
  import pfq_pkg::*;
#(
  parameter int NUM_FLOWS  = NUM_FLOWS_DEF,
  parameter int FLOW_DEPTH = FLOW_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // server_id[15:0], session_id[47:16], event_kind[49:48],
  // event_handle[81:50], zero fill[87:82]
  input  logic [TDATA_W-1:0]     in_tdata,
  // func[1:0]
  input  logic [FUNC_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_server[15:0], out_session[47:16], out_kind[49:48],
  // out_handle[81:50], zero fill[87:82]
  output logic [TDATA_W-1:0]     out_tdata,
  // status[2:0], event_valid[3]
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front end: take and decode transfers
  pfq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back end: table search, FIFO and ring updates, result register
  pfq_back #(
    .NUM_FLOWS  (NUM_FLOWS),
    .FLOW_DEPTH (FLOW_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );
endmodule

[hw/rtl/pfq_checker.sv]
// Port-level checks for the per-flow round-robin event queue, bound to the top.
// Uses pfq_pkg.
module pfq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [pfq_pkg::TDATA_W-1:0]     in_tdata,
  input logic [pfq_pkg::FUNC_W-1:0]      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pfq_pkg::TDATA_W-1:0]     out_tdata,
  input logic [pfq_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import pfq_pkg::*;

  // offered input holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input changed while stalled");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no event delivered: data fields are zero
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[3] |-> out_tdata == '0)
    else $error("data present without event");

  // a delivered event always reports ok
  a_ev_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[2:0] == STAT_OK)
    else $error("event with non-ok status");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:0] == STAT_OK || out_tuser[2:0] == STAT_EMPTY ||
      out_tuser[2:0] == STAT_TBL_FULL || out_tuser[2:0] == STAT_FIFO_FULL ||
      out_tuser[2:0] == STAT_REM_BUSY)
    else $error("bad status code");
endmodule

bind per_flow_round_robin_event_queue pfq_checker u_pfq_checker (.*);
